FILE: sv/program_stream_private_track_demux_unit_defines.svh
// ----------------------------------------------------------------------------
// Program stream private track demux - assertion macros
// Shared assertion helpers, clocked on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef PROGRAM_STREAM_PRIVATE_TRACK_DEMUX_UNIT_DEFINES_SVH
`define PROGRAM_STREAM_PRIVATE_TRACK_DEMUX_UNIT_DEFINES_SVH

// same-cycle implication
`define PSTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pstd_pkg.sv
// ----------------------------------------------------------------------------
// pstd_pkg
// Shared types and constants of the program stream private track demux.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pstd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_PROG_END = 2'd1;
  localparam logic [1:0] ST_BAD_PACK = 2'd2;

  localparam logic CFG_TRACK_SELECT = 1'b0;
  localparam logic CFG_RAW_PASSTHROUGH = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_start;
    logic [1:0] status;
  } res_t;

endpackage

FILE: sv/program_stream_private_track_demux_unit.sv
// ----------------------------------------------------------------------------
// program_stream_private_track_demux_unit
// Extracts one private stream 1 track from an MPEG-1/2 program stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_stream_byte): one program stream byte
// per transaction. Result channel (out_*): payload bytes of the selected
// track, with out_packet_start on the first byte of each packet, or a single
// status transaction (program end, malformed pack header) after which every
// further byte is consumed and dropped until reset.
// Configuration (cfg_we/cfg_index/cfg_wdata): index 0 track select, index 1
// raw passthrough; write only while the block is idle.
// Throughput: one byte per cycle while the queue has room; the parser updates
// its counters as each byte is taken. A result enters the queue at the edge
// that takes its byte and moves to the output register once that register
// is free or being read, so results are presented from a register.
// When the receiver stalls the queue of QUEUE_DEPTH entries fills, then
// in_ready drops until a slot frees. Reset is synchronous, active low, and
// returns the parser to start code hunting with default configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module program_stream_private_track_demux_unit
  import pstd_pkg::*;
#(
  parameter int QUEUE_DEPTH = pstd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_packet_start,
  output logic [1:0] out_status
);

  logic fire;
  logic res_valid;
  res_t res;
  logic q_full, q_nonempty, q_pop;
  res_t q_head;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;

  pstd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fire       (fire),
    .stream_byte(in_stream_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  pstd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  pstd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_payload_byte(out_payload_byte),
    .out_packet_start(out_packet_start),
    .out_status      (out_status)
  );

endmodule

FILE: sv/pstd_front.sv
// ----------------------------------------------------------------------------
// pstd_front
// Stream parser: start code hunt, pack/PES header stripping, track match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "program_stream_private_track_demux_unit_defines.svh"

module pstd_front
  import pstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       fire,
  input  logic [7:0] stream_byte,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [15:0] {
    PH_HUNT      = 16'h0001,
    PH_CODE      = 16'h0002,
    PH_PACK_HEAD = 16'h0004,
    PH_PACK_BODY = 16'h0008,
    PH_PACK_TAIL = 16'h0010,
    PH_LEN_HI    = 16'h0020,
    PH_LEN_LO    = 16'h0040,
    PH_SKIP_PKT  = 16'h0080,
    PH_PES_FIRST = 16'h0100,
    PH_M2_HDR    = 16'h0200,
    PH_HDR_SKIP  = 16'h0400,
    PH_M1_SCAN   = 16'h0800,
    PH_M1_STD    = 16'h1000,
    PH_M1_TS     = 16'h2000,
    PH_SUBSTREAM = 16'h4000,
    PH_PAYLOAD   = 16'h8000
  } phase_t;

  localparam logic [23:0] WIN_IDLE = 24'hffffff;
  localparam logic [23:0] START_CODE = 24'h000001;
  localparam logic [7:0]  SID_END = 8'hb9;
  localparam logic [7:0]  SID_PACK = 8'hba;
  localparam logic [7:0]  SID_PRIV1 = 8'hbd;

  logic [7:0]  track_r;
  logic        raw_r;
  logic [23:0] win_r, win_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [3:0]  hpos_r, hpos_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [4:0]  stuff_r, stuff_nxt;
  logic [7:0]  sid_r, sid_nxt;
  logic        mpeg2_r, mpeg2_nxt;
  logic        first_r, first_nxt;
  logic        halted_r, halted_nxt;

  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_first;
  logic [1:0]  emit_status;
  logic        body;
  logic [23:0] win_shift;
  logic [7:0]  skip_dec;
  logic [15:0] rem_dec;
  phase_t      ts_phase, m1_phase;
  logic [7:0]  ts_skip, m1_skip;
  logic [4:0]  m1_stuff;

  assign win_shift = {win_r[15:0], stream_byte};
  assign skip_dec = (skip_r != 8'd0) ? skip_r - 8'd1 : 8'd0;

  // timestamp code nibble of an MPEG-1 header
  always_comb begin
    ts_skip = skip_r;
    case (stream_byte[7:4])
      4'h0: begin
        ts_phase = PH_SUBSTREAM;
        ts_skip = 8'd0;
      end
      4'h2: begin
        ts_phase = PH_HDR_SKIP;
        ts_skip = 8'd4;
      end
      4'h3: begin
        ts_phase = PH_HDR_SKIP;
        ts_skip = 8'd9;
      end
      default: ts_phase = PH_SKIP_PKT;
    endcase
  end

  // MPEG-1 stuffing / STD scan
  always_comb begin
    m1_stuff = stuff_r;
    m1_skip = skip_r;
    if (stream_byte == 8'hff) begin
      if (stuff_r[4]) begin
        m1_phase = PH_SKIP_PKT;
      end else begin
        m1_stuff = stuff_r + 5'd1;
        m1_phase = PH_M1_SCAN;
      end
    end else if (stream_byte[7:6] == 2'b01) begin
      m1_phase = PH_M1_STD;
    end else begin
      m1_phase = ts_phase;
      m1_skip = ts_skip;
    end
  end

  always_comb begin
    win_nxt = win_r;
    phase_nxt = phase_r;
    rem_nxt = rem_r;
    hpos_nxt = hpos_r;
    skip_nxt = skip_r;
    stuff_nxt = stuff_r;
    sid_nxt = sid_r;
    mpeg2_nxt = mpeg2_r;
    first_nxt = first_r;
    halted_nxt = halted_r;
    emit = 1'b0;
    emit_byte = 8'd0;
    emit_first = 1'b0;
    emit_status = ST_PAYLOAD;
    body = 1'b0;
    rem_dec = 16'd0;
    if (!halted_r) begin
      case (phase_r)
        PH_HUNT: begin
          win_nxt = win_shift;
          if (win_shift == START_CODE) begin
            win_nxt = WIN_IDLE;
            phase_nxt = PH_CODE;
          end
        end
        PH_CODE: begin
          sid_nxt = stream_byte;
          if (stream_byte == SID_END) begin
            emit = 1'b1;
            emit_status = ST_PROG_END;
            halted_nxt = 1'b1;
          end else begin
            phase_nxt = (stream_byte == SID_PACK) ? PH_PACK_HEAD : PH_LEN_HI;
          end
        end
        PH_PACK_HEAD: begin
          if (stream_byte[7:6] == 2'b01) begin
            mpeg2_nxt = 1'b1;
            hpos_nxt = 4'd5;
            phase_nxt = PH_PACK_BODY;
          end else if (stream_byte[7:4] == 4'h2) begin
            mpeg2_nxt = 1'b0;
            skip_nxt = 8'd7;
            phase_nxt = PH_PACK_TAIL;
          end else begin
            emit = 1'b1;
            emit_status = ST_BAD_PACK;
            halted_nxt = 1'b1;
          end
        end
        PH_PACK_BODY: begin
          if (hpos_r >= 4'd13) begin
            skip_nxt = {5'd0, stream_byte[2:0]};
            phase_nxt = (stream_byte[2:0] == 3'd0) ? PH_HUNT : PH_PACK_TAIL;
          end else begin
            hpos_nxt = hpos_r + 4'd1;
          end
        end
        PH_PACK_TAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) phase_nxt = PH_HUNT;
        end
        PH_LEN_HI: begin
          rem_nxt = {stream_byte, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rem_nxt = {rem_r[15:8], stream_byte};
          stuff_nxt = 5'd0;
          hpos_nxt = 4'd0;
          skip_nxt = 8'd0;
          first_nxt = 1'b0;
          if ({rem_r[15:8], stream_byte} == 16'd0) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = (sid_r == SID_PRIV1) ? PH_PES_FIRST : PH_SKIP_PKT;
          end
        end
        PH_SKIP_PKT: body = 1'b1;
        PH_PES_FIRST: begin
          body = 1'b1;
          if (stream_byte[7:6] == 2'b10) begin
            mpeg2_nxt = 1'b1;
            hpos_nxt = 4'd0;
            phase_nxt = PH_M2_HDR;
          end else begin
            mpeg2_nxt = 1'b0;
            phase_nxt = m1_phase;
            skip_nxt = m1_skip;
            stuff_nxt = m1_stuff;
          end
        end
        PH_M2_HDR: begin
          body = 1'b1;
          if (hpos_r == 4'd0) begin
            hpos_nxt = 4'd1;
          end else begin
            skip_nxt = stream_byte;
            phase_nxt = (stream_byte == 8'd0) ? PH_SUBSTREAM : PH_HDR_SKIP;
          end
        end
        PH_HDR_SKIP: begin
          body = 1'b1;
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) phase_nxt = PH_SUBSTREAM;
        end
        PH_M1_SCAN: begin
          body = 1'b1;
          phase_nxt = m1_phase;
          skip_nxt = m1_skip;
          stuff_nxt = m1_stuff;
        end
        PH_M1_STD: begin
          body = 1'b1;
          phase_nxt = PH_M1_TS;
        end
        PH_M1_TS: begin
          body = 1'b1;
          phase_nxt = ts_phase;
          skip_nxt = ts_skip;
        end
        PH_SUBSTREAM: begin
          body = 1'b1;
          if (raw_r || (stream_byte == track_r && track_r < 8'h40)) begin
            skip_nxt = 8'd0;
            phase_nxt = PH_PAYLOAD;
            emit = 1'b1;
            emit_byte = stream_byte;
            emit_first = 1'b1;
            first_nxt = 1'b0;
          end else if (stream_byte == track_r && track_r[7]) begin
            first_nxt = 1'b1;
            skip_nxt = 8'd3;
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_SKIP_PKT;
          end
        end
        PH_PAYLOAD: begin
          body = 1'b1;
          if (skip_r != 8'd0) begin
            skip_nxt = skip_dec;
          end else begin
            emit = 1'b1;
            emit_byte = stream_byte;
            emit_first = first_r;
            first_nxt = 1'b0;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
      if (body) begin
        rem_dec = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt = PH_HUNT;
          win_nxt = WIN_IDLE;
        end
      end
    end
  end

  assign res_valid = fire && emit;
  assign res = '{payload_byte: emit_byte, packet_start: emit_first, status: emit_status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 8'd128;
      raw_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRACK_SELECT: track_r <= cfg_wdata;
        CFG_RAW_PASSTHROUGH: raw_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_IDLE;
      phase_r <= PH_HUNT;
      rem_r <= 16'd0;
      hpos_r <= 4'd0;
      skip_r <= 8'd0;
      stuff_r <= 5'd0;
      sid_r <= 8'd0;
      mpeg2_r <= 1'b0;
      first_r <= 1'b0;
      halted_r <= 1'b0;
    end else if (fire) begin
      win_r <= win_nxt;
      phase_r <= phase_nxt;
      rem_r <= rem_nxt;
      hpos_r <= hpos_nxt;
      skip_r <= skip_nxt;
      stuff_r <= stuff_nxt;
      sid_r <= sid_nxt;
      mpeg2_r <= mpeg2_nxt;
      first_r <= first_nxt;
      halted_r <= halted_nxt;
    end
  end

  `PSTD_ASSERT_NEXT(a_halt_sticks, halted_r, halted_r, "halted cleared without reset")
  `PSTD_ASSERT_NEXT(a_status_halts, res_valid && res.status != ST_PAYLOAD, halted_r,
                    "status transaction did not halt the parser")
  `PSTD_ASSERT_NOW(a_no_result_halted, halted_r, !res_valid, "result while halted")
  `PSTD_ASSERT_NOW(a_stuff_bound, 1'b1, stuff_r <= 5'd16, "stuffing count overrun")

endmodule

FILE: sv/pstd_queue.sv
// ----------------------------------------------------------------------------
// pstd_queue
// Small register queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "program_stream_private_track_demux_unit_defines.svh"

module pstd_queue
  import pstd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output res_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full = (cnt_r == CNT_FULL);
  assign nonempty = (cnt_r != '0);
  assign head = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
      if (pop) rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `PSTD_ASSERT_NOW(a_no_overflow, full, !push, "push into full queue")
  `PSTD_ASSERT_NOW(a_no_underflow, !nonempty, !pop, "pop from empty queue")
  `PSTD_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1,
                    "queue count did not advance")

endmodule

FILE: sv/pstd_back.sv
// ----------------------------------------------------------------------------
// pstd_back
// Output register stage driving the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pstd_back
  import pstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nonempty,
  input  res_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_packet_start,
  output logic [1:0] out_status
);

  logic out_valid_r;
  res_t out_data_r;

  assign q_pop = q_nonempty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_payload_byte = out_data_r.payload_byte;
  assign out_packet_start = out_data_r.packet_start;
  assign out_status = out_data_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= q_head;
  end

endmodule

FILE: verif/program_stream_private_track_demux_unit_test.sv
// ----------------------------------------------------------------------------
// program_stream_private_track_demux_unit_test
// Self-checking bench for the private track demux. A byte-level parser model
// predicts every payload and status result from the accepted stream bytes.
// The stream is built from well-formed packs and PES packets with random
// content, plus noise and cut-short packets. Five written register settings
// and the reset default are covered under varying back-pressure. The run ends
// on a program end code or on a malformed pack header, chosen at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module program_stream_private_track_demux_unit_test;
  import pstd_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_BYTES_PER_PHASE = 120;
  localparam int NUM_PHASES = 5;

  localparam logic [7:0] SID_END = 8'hB9;
  localparam logic [7:0] SID_PACK = 8'hBA;
  localparam logic [7:0] SID_PRIV1 = 8'hBD;

  localparam logic [7:0] PHASE_TRACK [NUM_PHASES] = '{8'h00, 8'hFF, 8'h50, 8'h3F, 8'h00};
  localparam logic PHASE_PASS [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam int SEND_IDLE [NUM_PHASES] = '{19, 57, 57, 0, 0};
  localparam int RECV_IDLE [NUM_PHASES] = '{57, 19, 19, 0, 0};
  localparam logic [3:0] BAD_TS_NIBBLE [4] = '{4'h1, 4'hC, 4'hD, 4'hE};

  // audio packet on the reset track, then zero length, cut header, video
  localparam logic [7:0] DIRECTED_SEQ [36] = '{
    8'h00, 8'h00, 8'h01, 8'hBD, 8'h00, 8'h09, 8'h80, 8'h80, 8'h00, 8'h80,
    8'h11, 8'h22, 8'h33, 8'h00, 8'hFF,
    8'h00, 8'h00, 8'h01, 8'hBD, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h01, 8'hBD, 8'h00, 8'h02, 8'h81, 8'hC0,
    8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h01, 8'hFF
  };

  typedef enum logic [3:0] {
    PS_HUNT, PS_CODE, PS_PACK_HEAD, PS_PACK_BODY, PS_PACK_TAIL, PS_LEN_HI,
    PS_LEN_LO, PS_SKIP_PKT, PS_PES_FIRST, PS_M2_HDR, PS_HDR_SKIP, PS_M1_SCAN,
    PS_M1_STD, PS_M1_TS, PS_SUBSTREAM, PS_PAYLOAD
  } parse_state_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_stream_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_packet_start;
  logic [1:0] out_status;

  program_stream_private_track_demux_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_packet_start (out_packet_start),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // parser model state and register copy
  logic [23:0]  sync_window;
  parse_state_t parse_state;
  logic [15:0]  pkt_left;
  logic [7:0]   hdr_pos;
  logic [7:0]   skip_left;
  logic [4:0]   stuff_cnt;
  logic [7:0]   stream_id;
  logic         mpeg2_flag;
  logic         first_flag;
  logic         stopped;
  logic [7:0]   sel_track;
  logic         pass_all;

  logic [7:0] stream_bytes_q [$];
  res_t       expected_results_q [$];
  logic [7:0] pes_body [$];

  res_t predicted;
  res_t oldest;
  bit   in_taken = 1'b0;
  bit   long_hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase_bytes = 0;
  int   quiet_cycles = 0;
  int   errors = 0;
  int   bytes_in = 0;
  int   payload_seen = 0;
  int   starts_seen = 0;
  int   status_seen = 0;

  function automatic void reset_parser();
    sync_window = '1;
    parse_state = PS_HUNT;
    pkt_left = 16'd0;
    hdr_pos = 8'd0;
    skip_left = 8'd0;
    stuff_cnt = 5'd0;
    stream_id = 8'd0;
    mpeg2_flag = 1'b0;
    first_flag = 1'b0;
    stopped = 1'b0;
    sel_track = 8'h80;
    pass_all = 1'b0;
  endfunction

  function automatic void skip_to_substream(input logic [7:0] n);
    skip_left = n;
    parse_state = (n == 8'd0) ? PS_SUBSTREAM : PS_HDR_SKIP;
  endfunction

  function automatic void timestamp_field(input logic [7:0] b);
    case (b[7:4])
      4'h0: skip_to_substream(8'd0);
      4'h2: skip_to_substream(8'd4);
      4'h3: skip_to_substream(8'd9);
      default: parse_state = PS_SKIP_PKT;
    endcase
  endfunction

  function automatic void mpeg1_field(input logic [7:0] b);
    if (b == 8'hFF) begin
      if (stuff_cnt >= 5'd16) begin
        parse_state = PS_SKIP_PKT;
      end else begin
        stuff_cnt++;
        parse_state = PS_M1_SCAN;
      end
    end else if (b[7:6] == 2'b01) begin
      parse_state = PS_M1_STD;
    end else begin
      timestamp_field(b);
    end
  endfunction

  function automatic res_t payload_result(input logic [7:0] b);
    res_t r;
    r.payload_byte = b;
    r.packet_start = first_flag;
    r.status = ST_PAYLOAD;
    first_flag = 1'b0;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    bit hit;
    bit body;
    hit = 1'b0;
    body = 1'b0;
    r = '0;
    if (stopped) return 1'b0;
    case (parse_state)
      PS_HUNT: begin
        sync_window = {sync_window[15:0], b};
        if (sync_window == 24'h000001) begin
          sync_window = '1;
          parse_state = PS_CODE;
        end
      end
      PS_CODE: begin
        stream_id = b;
        if (b == SID_END) begin
          r.status = ST_PROG_END;
          stopped = 1'b1;
          hit = 1'b1;
        end else begin
          parse_state = (b == SID_PACK) ? PS_PACK_HEAD : PS_LEN_HI;
        end
      end
      PS_PACK_HEAD: begin
        if (b[7:6] == 2'b01) begin
          mpeg2_flag = 1'b1;
          hdr_pos = 8'd5;
          parse_state = PS_PACK_BODY;
        end else if (b[7:4] == 4'h2) begin
          mpeg2_flag = 1'b0;
          skip_left = 8'd7;
          parse_state = PS_PACK_TAIL;
        end else begin
          r.status = ST_BAD_PACK;
          stopped = 1'b1;
          hit = 1'b1;
        end
      end
      PS_PACK_BODY: begin
        if (hdr_pos >= 8'd13) begin
          skip_left = {5'b0, b[2:0]};
          parse_state = (b[2:0] == 3'd0) ? PS_HUNT : PS_PACK_TAIL;
        end else begin
          hdr_pos++;
        end
      end
      PS_PACK_TAIL: begin
        if (skip_left != 8'd0) skip_left--;
        if (skip_left == 8'd0) parse_state = PS_HUNT;
      end
      PS_LEN_HI: begin
        pkt_left = {b, 8'h00};
        parse_state = PS_LEN_LO;
      end
      PS_LEN_LO: begin
        pkt_left = {pkt_left[15:8], b};
        stuff_cnt = 5'd0;
        hdr_pos = 8'd0;
        skip_left = 8'd0;
        first_flag = 1'b0;
        if (pkt_left == 16'd0)
          parse_state = PS_HUNT;
        else
          parse_state = (stream_id == SID_PRIV1) ? PS_PES_FIRST : PS_SKIP_PKT;
      end
      default: body = 1'b1;
    endcase
    if (body) begin
      case (parse_state)
        PS_PES_FIRST: begin
          if (b[7:6] == 2'b10) begin
            mpeg2_flag = 1'b1;
            hdr_pos = 8'd0;
            parse_state = PS_M2_HDR;
          end else begin
            mpeg2_flag = 1'b0;
            mpeg1_field(b);
          end
        end
        PS_M2_HDR: begin
          if (hdr_pos == 8'd0)
            hdr_pos = 8'd1;
          else
            skip_to_substream(b);
        end
        PS_HDR_SKIP: begin
          if (skip_left != 8'd0) skip_left--;
          if (skip_left == 8'd0) parse_state = PS_SUBSTREAM;
        end
        PS_M1_SCAN: mpeg1_field(b);
        PS_M1_STD: parse_state = PS_M1_TS;
        PS_M1_TS: timestamp_field(b);
        PS_SUBSTREAM: begin
          if (pass_all || (b == sel_track && sel_track < 8'h40)) begin
            first_flag = 1'b1;
            skip_left = 8'd0;
            parse_state = PS_PAYLOAD;
            r = payload_result(b);
            hit = 1'b1;
          end else if (b == sel_track && sel_track >= 8'h80) begin
            first_flag = 1'b1;
            skip_left = 8'd3;
            parse_state = PS_PAYLOAD;
          end else begin
            parse_state = PS_SKIP_PKT;
          end
        end
        PS_PAYLOAD: begin
          if (skip_left != 8'd0) begin
            skip_left--;
          end else begin
            r = payload_result(b);
            hit = 1'b1;
          end
        end
        default: ;
      endcase
      if (pkt_left != 16'd0) pkt_left--;
      if (pkt_left == 16'd0) begin
        parse_state = PS_HUNT;
        sync_window = '1;
      end
    end
    return hit;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    stream_bytes_q.push_back(b);
    phase_bytes++;
  endtask

  task automatic queue_start(input logic [7:0] id);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(id);
  endtask

  task automatic put_pes(input logic [7:0] id, input int declared);
    queue_start(id);
    queue_byte(declared[15:8]);
    queue_byte(declared[7:0]);
    for (int i = 0; i < declared; i++) queue_byte(pes_body[i]);
    pes_body.delete();
  endtask

  task automatic put_noise();
    logic [7:0] b;
    // no 0x01, so noise alone never completes a start code
    repeat ($urandom_range(1, 6)) begin
      b = ($urandom_range(0, 9) < 3) ? 8'h00 : rnd_byte();
      if (b == 8'h01) b = 8'h02;
      queue_byte(b);
    end
  endtask

  task automatic put_pack();
    logic [2:0] n;
    queue_start(SID_PACK);
    if ($urandom_range(0, 1) == 1) begin
      n = 3'($urandom_range(0, 7));
      queue_byte({2'b01, 6'($urandom_range(0, 63))});
      repeat (8) queue_byte(rnd_byte());
      queue_byte({5'($urandom_range(0, 31)), n});
      repeat (n) queue_byte(rnd_byte());
    end else begin
      queue_byte({4'h2, 4'($urandom_range(0, 15))});
      repeat (7) queue_byte(rnd_byte());
    end
  endtask

  task automatic put_other();
    logic [7:0] id;
    int n;
    do id = rnd_byte(); while (id == SID_END || id == SID_PACK || id == SID_PRIV1);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 16);
    repeat (n) pes_body.push_back(rnd_byte());
    put_pes(id, n);
  endtask

  task automatic put_private(input bit cut);
    logic [7:0] sub;
    int hdr;
    int declared;
    sub = ($urandom_range(0, 99) < 55) ? sel_track : rnd_byte();
    if ($urandom_range(0, 1) == 1) begin
      hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
      pes_body.push_back({2'b10, 6'($urandom_range(0, 63))});
      pes_body.push_back(rnd_byte());
      pes_body.push_back(8'(hdr));
      repeat (hdr) pes_body.push_back(rnd_byte());
    end else begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 3))
        pes_body.push_back(8'hFF);
      if ($urandom_range(0, 1) == 1) begin
        pes_body.push_back({2'b01, 6'($urandom_range(0, 63))});
        pes_body.push_back(rnd_byte());
      end
      case ($urandom_range(0, 6))
        0, 1: pes_body.push_back({4'h0, 4'($urandom_range(0, 15))});
        2, 3: begin
          pes_body.push_back({4'h2, 4'($urandom_range(0, 15))});
          repeat (4) pes_body.push_back(rnd_byte());
        end
        4, 5: begin
          pes_body.push_back({4'h3, 4'($urandom_range(0, 15))});
          repeat (9) pes_body.push_back(rnd_byte());
        end
        default:
          pes_body.push_back({BAD_TS_NIBBLE[$urandom_range(0, 3)], 4'($urandom_range(0, 15))});
      endcase
    end
    pes_body.push_back(sub);
    repeat ($urandom_range(0, 12)) pes_body.push_back(rnd_byte());
    declared = cut ? $urandom_range(0, pes_body.size() - 1) : pes_body.size();
    put_pes(SID_PRIV1, declared);
  endtask

  task automatic put_random_unit();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) put_noise();
    else if (k < 22) put_pack();
    else if (k < 34) put_other();
    else put_private(k >= 88);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_TRACK_SELECT) sel_track = val;
    else pass_all = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (stream_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (stream_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_stream_byte <= stream_bytes_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      in_taken = 1'b1;
      bytes_in++;
      if (parse_byte(in_stream_byte, predicted)) expected_results_q.push_back(predicted);
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h start %0b status %0d",
                                  out_payload_byte, out_packet_start, out_status));
      end else begin
        oldest = expected_results_q.pop_front();
        if (out_payload_byte !== oldest.payload_byte)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                                    out_payload_byte, oldest.payload_byte));
        if (out_packet_start !== oldest.packet_start)
          report_mismatch($sformatf("packet_start %0b, want %0b",
                                    out_packet_start, oldest.packet_start));
        if (out_status !== oldest.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, oldest.status));
        if (oldest.status == ST_PAYLOAD) payload_seen++;
        else status_seen++;
        if (oldest.packet_start) starts_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] bad;
    reset_parser();
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 36; i++) queue_byte(DIRECTED_SEQ[i]);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_idle_pct = RECV_IDLE[p];
      write_reg(CFG_TRACK_SELECT,
                (p == NUM_PHASES - 1) ? rnd_byte() : PHASE_TRACK[p]);
      write_reg(CFG_RAW_PASSTHROUGH, {7'b0, PHASE_PASS[p]});
      if (p == 3) long_hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < RANDOM_BYTES_PER_PHASE) put_random_unit();
      if (p == NUM_PHASES - 1) begin
        if ($urandom_range(0, 1) == 1) begin
          queue_start(SID_END);
        end else begin
          queue_start(SID_PACK);
          do bad = rnd_byte(); while (bad[7:6] == 2'b01 || bad[7:4] == 4'h2);
          queue_byte(bad);
        end
        // dropped once halted
        repeat (8) queue_byte(rnd_byte());
      end
      wait_idle();
    end

    if (expected_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results_q.size()));
    $display("Covered %0d stream bytes over %0d register settings, packs, PES and noise.",
             bytes_in, NUM_PHASES + 1);
    $display("Checked %0d payload bytes (%0d packet starts) and %0d status results.",
             payload_seen, starts_seen, status_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: program_stream_private_track_demux_unit.f
+incdir+sv
sv/pstd_pkg.sv
sv/pstd_front.sv
sv/pstd_queue.sv
sv/pstd_back.sv
sv/program_stream_private_track_demux_unit.sv
verif/program_stream_private_track_demux_unit_test.sv
